FILE: hdl/poh_pkg.sv
package poh_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_LEVELS = 16;
    localparam int COUNT_BITS = 21;

    localparam int MAP_COLS  = MAX_WIDTH + 1;
    localparam int MAP_ROWS  = MAX_HEIGHT + 1;
    localparam int MAP_DEPTH = MAP_COLS * MAP_ROWS;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int COL_AW    = $clog2(MAP_COLS);
    localparam int ROW_AW    = $clog2(MAP_ROWS);
    localparam int LVL_W     = $clog2(MAX_LEVELS + 1);

    localparam int DIM_W   = 9;
    localparam int RATIO_W = 16;
    localparam int SCALE_W = 17;
    localparam int SCORE_W = 20;
    localparam int CX_W    = 18;

    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(65536);

    // Configuration register indexes.
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_PATCH_SIZE   = 3'd2;
    localparam logic [2:0] REG_STRIDE_STEP  = 3'd3;
    localparam logic [2:0] REG_MIN_WIDTH    = 3'd4;
    localparam logic [2:0] REG_SHRINK_RATIO = 3'd5;

    // Effective geometry after the out-of-range fixes.
    typedef struct packed {
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [DIM_W-1:0]   p;
        logic [DIM_W-1:0]   st;
        logic [DIM_W-1:0]   min_w;
        logic [RATIO_W-1:0] ratio;
    } cfg_t;

    typedef struct packed {
        logic       walk_reset;
        logic       lev_eval;
        logic       chk_eval;
        logic       next_level;
        logic       corner_eval;
        logic       scale_eval;
        logic       corner_rd;
        logic       corner_wr;
        logic [1:0] corner_sel;
        logic       advance;
        logic       clr_step;
        logic       sw_start;
        logic       sw_rd;
        logic       sw_wr;
    } cmd_t;

    typedef struct packed {
        logic lvl_ok;
        logic fits;
        logic row_ok;
        logic clr_last;
        logic sw_last;
    } sts_t;

endpackage

FILE: hdl/poh_ram.sv
module poh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/poh_ctrl.sv
module poh_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          is_face,
    input  logic          last_patch,
    input  poh_pkg::sts_t sts,
    output poh_pkg::cmd_t cmd,
    output logic          busy,
    output logic          score_valid
);
    import poh_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_LEV  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_ROW  = 4'd4;
    localparam logic [3:0] S_CX   = 4'd5;
    localparam logic [3:0] S_SC   = 4'd6;
    localparam logic [3:0] S_CRD  = 4'd7;
    localparam logic [3:0] S_CWR  = 4'd8;
    localparam logic [3:0] S_ADV  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;
    localparam logic [3:0] S_SRD  = 4'd11;
    localparam logic [3:0] S_SWR  = 4'd12;
    localparam logic [3:0] S_EMIT = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic       face_reg, face_next;
    logic       last_reg, last_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        face_next  = face_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.corner_sel = idx_reg;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    face_next  = is_face;
                    last_next  = last_patch;
                    state_next = S_LEV;
                end
            end
            S_LEV:
            begin
                cmd.lev_eval = 1'b1;
                state_next   = S_CHK;
            end
            S_CHK:
            begin
                priority if (!sts.lvl_ok)
                begin
                    state_next = S_FIN;
                end
                else if (sts.fits)
                begin
                    cmd.chk_eval = 1'b1;
                    state_next   = S_ROW;
                end
                else
                begin
                    cmd.next_level = 1'b1;
                    state_next     = S_LEV;
                end
            end
            S_ROW:
            begin
                priority if (!sts.row_ok)
                begin
                    cmd.next_level = 1'b1;
                    state_next     = S_LEV;
                end
                else if (face_reg)
                begin
                    state_next = S_CX;
                end
                else
                begin
                    state_next = S_ADV;
                end
            end
            S_CX:
            begin
                cmd.corner_eval = 1'b1;
                state_next      = S_SC;
            end
            S_SC:
            begin
                cmd.scale_eval = 1'b1;
                idx_next       = 2'd0;
                state_next     = S_CRD;
            end
            S_CRD:
            begin
                cmd.corner_rd = 1'b1;
                state_next    = S_CWR;
            end
            S_CWR:
            begin
                cmd.corner_wr = 1'b1;
                idx_next      = idx_reg + 2'd1;
                state_next    = (idx_reg == 2'd3) ? S_ADV : S_CRD;
            end
            S_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (last_reg)
                begin
                    cmd.sw_start = 1'b1;
                    state_next   = S_SRD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SRD:
            begin
                cmd.sw_rd  = 1'b1;
                state_next = S_SWR;
            end
            S_SWR:
            begin
                cmd.sw_wr  = 1'b1;
                state_next = sts.sw_last ? S_EMIT : S_SRD;
            end
            S_EMIT:
            begin
                cmd.walk_reset = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            idx_reg   <= 2'd0;
            face_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            face_reg  <= face_next;
            last_reg  <= last_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign score_valid = (state_reg == S_EMIT);

    a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
        score_valid |=> !score_valid) else $error("score strobe longer than one cycle");
    a_emit_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        score_valid |-> $past(state_reg == S_SWR)) else $error("score without sweep");
    a_rmw_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CWR) |-> $past(state_reg == S_CRD)) else $error("write without read");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEV && $past(state_reg == S_IDLE)) |-> $past(start))
        else $error("walk began without a start");

endmodule

FILE: hdl/poh_datapath.sv
module poh_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  poh_pkg::cfg_t                 cfg,
    input  poh_pkg::cmd_t                 cmd,
    output poh_pkg::sts_t                 sts,
    output logic [poh_pkg::SCORE_W-1:0]   score
);
    import poh_pkg::*;

    logic [LVL_W-1:0]      level_reg, level_next;
    logic [SCALE_W-1:0]    scale_reg, scale_next;
    logic [COL_AW-1:0]     col_reg, col_next;
    logic [ROW_AW-1:0]     row_reg, row_next;
    logic [DIM_W-1:0]      tw_reg, tw_next, th_reg, th_next;
    logic                  exists_reg, exists_next;
    logic [CX_W-1:0]       cx_reg, cx_next, ry_reg, ry_next;
    logic [DIM_W-1:0]      x0_reg, x0_next, x1_reg, x1_next;
    logic [DIM_W-1:0]      y0_reg, y0_next, y1_reg, y1_next;
    logic [MAP_AW-1:0]     addr_reg, addr_next;
    logic [COL_AW-1:0]     x_reg, x_next;
    logic [ROW_AW-1:0]     y_reg, y_next;
    logic [COUNT_BITS-1:0] rowsum_reg, rowsum_next;
    logic [SCORE_W-1:0]    max_reg, max_next;

    logic [25:0]           wprod, hprod;
    logic [32:0]           sprod;
    logic [18:0]           colprod, rowprod, nprod;
    logic [COL_AW-1:0]     ncol;
    logic [DIM_W-1:0]      xs, ys;
    logic [MAP_AW-1:0]     caddr;
    logic                  plus;
    logic [COUNT_BITS-1:0] m_rdata, rb_rdata, up, rs, psum, m_wdata;
    logic [MAP_AW-1:0]     m_raddr, m_waddr;
    logic                  m_we;
    logic                  last_cell;

    function automatic logic [DIM_W-1:0] scale_clip(input logic [CX_W-1:0] v,
                                                    input logic [SCALE_W-1:0] s,
                                                    input logic [DIM_W-1:0] lim);
        logic [34:0] prod;
        logic [18:0] r;
        prod = 35'(v) * 35'(s);
        r    = prod[34:16];
        return (r > 19'(lim)) ? lim : r[DIM_W-1:0];
    endfunction

    assign wprod   = 26'(cfg.w) * 26'(scale_reg);
    assign hprod   = 26'(cfg.h) * 26'(scale_reg);
    assign sprod   = 33'(scale_reg) * 33'(cfg.ratio);
    assign colprod = 19'(col_reg) * 19'(cfg.st) + 19'(cfg.p);
    assign rowprod = 19'(row_reg) * 19'(cfg.st) + 19'(cfg.p);
    assign ncol    = col_reg + COL_AW'(1);
    assign nprod   = 19'(ncol) * 19'(cfg.st) + 19'(cfg.p);

    assign xs    = cmd.corner_sel[0] ? x1_reg : x0_reg;
    assign ys    = cmd.corner_sel[1] ? y1_reg : y0_reg;
    assign caddr = MAP_AW'(ys) * MAP_AW'(MAP_COLS) + MAP_AW'(xs);
    assign plus  = (cmd.corner_sel[0] == cmd.corner_sel[1]);

    assign up   = (y_reg == '0) ? '0 : rb_rdata;
    assign rs   = ((x_reg == '0) ? '0 : rowsum_reg) + m_rdata;
    assign psum = up + rs;
    assign last_cell = (addr_reg == MAP_AW'(MAP_DEPTH - 1));

    assign m_raddr = cmd.sw_rd ? addr_reg : caddr;
    assign m_we    = cmd.corner_wr | cmd.clr_step | cmd.sw_wr;
    assign m_waddr = cmd.corner_wr ? caddr : addr_reg;
    assign m_wdata = cmd.corner_wr ? (plus ? m_rdata + COUNT_BITS'(1)
                                           : m_rdata - COUNT_BITS'(1)) : '0;

    always_comb
    begin
        level_next  = level_reg;
        scale_next  = scale_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        tw_next     = tw_reg;
        th_next     = th_reg;
        exists_next = exists_reg;
        cx_next     = cx_reg;
        ry_next     = ry_reg;
        x0_next     = x0_reg;
        x1_next     = x1_reg;
        y0_next     = y0_reg;
        y1_next     = y1_reg;
        addr_next   = addr_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        rowsum_next = rowsum_reg;
        max_next    = max_reg;
        if (cmd.lev_eval)
        begin
            tw_next     = wprod[24:16];
            th_next     = hprod[24:16];
            exists_next = (wprod >= 26'({cfg.min_w, 16'd0}));
        end
        if (cmd.chk_eval && (colprod > 19'(tw_reg)))
        begin
            col_next = '0;
            row_next = row_reg + ROW_AW'(1);
        end
        if (cmd.next_level)
        begin
            level_next = level_reg + LVL_W'(1);
            scale_next = sprod[32:16];
            col_next   = '0;
            row_next   = '0;
        end
        if (cmd.corner_eval)
        begin
            cx_next = CX_W'(col_reg) * CX_W'(cfg.st);
            ry_next = CX_W'(row_reg) * CX_W'(cfg.st);
        end
        if (cmd.scale_eval)
        begin
            x0_next = scale_clip(cx_reg, scale_reg, cfg.w);
            x1_next = scale_clip(cx_reg + CX_W'(cfg.p), scale_reg, cfg.w);
            y0_next = scale_clip(ry_reg, scale_reg, cfg.h);
            y1_next = scale_clip(ry_reg + CX_W'(cfg.p), scale_reg, cfg.h);
        end
        if (cmd.advance)
        begin
            if (nprod > 19'(tw_reg))
            begin
                col_next = '0;
                row_next = row_reg + ROW_AW'(1);
            end
            else
            begin
                col_next = ncol;
            end
        end
        if (cmd.clr_step)
        begin
            addr_next = last_cell ? '0 : addr_reg + MAP_AW'(1);
        end
        if (cmd.sw_start)
        begin
            addr_next = '0;
            x_next    = '0;
            y_next    = '0;
            max_next  = '0;
        end
        if (cmd.sw_wr)
        begin
            addr_next   = addr_reg + MAP_AW'(1);
            rowsum_next = rs;
            if (x_reg == COL_AW'(MAP_COLS - 1))
            begin
                x_next = '0;
                y_next = y_reg + ROW_AW'(1);
            end
            else
            begin
                x_next = x_reg + COL_AW'(1);
            end
            if (!psum[COUNT_BITS-1] && (SCORE_W'(psum) > max_reg))
            begin
                max_next = SCORE_W'(psum);
            end
        end
        if (cmd.walk_reset)
        begin
            level_next = '0;
            scale_next = SCALE_ONE;
            col_next   = '0;
            row_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            scale_reg <= SCALE_ONE;
            col_reg   <= '0;
            row_reg   <= '0;
            addr_reg  <= '0;
            max_reg   <= '0;
        end
        else
        begin
            level_reg <= level_next;
            scale_reg <= scale_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            addr_reg  <= addr_next;
            max_reg   <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tw_reg     <= tw_next;
        th_reg     <= th_next;
        exists_reg <= exists_next;
        cx_reg     <= cx_next;
        ry_reg     <= ry_next;
        x0_reg     <= x0_next;
        x1_reg     <= x1_next;
        y0_reg     <= y0_next;
        y1_reg     <= y1_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        rowsum_reg <= rowsum_next;
    end

    poh_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAP_DEPTH)) u_map (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    // Holds the finished prefix sums of the row above the current one.
    poh_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAP_COLS)) u_rowbuf (
        .clk   (clk),
        .we    (cmd.sw_wr),
        .waddr (x_reg),
        .wdata (psum),
        .raddr (x_reg),
        .rdata (rb_rdata)
    );

    assign sts.lvl_ok   = (level_reg < LVL_W'(MAX_LEVELS)) && exists_reg;
    assign sts.fits     = (tw_reg >= cfg.p) && (th_reg >= cfg.p);
    assign sts.row_ok   = (rowprod <= 19'(th_reg));
    assign sts.clr_last = last_cell;
    assign sts.sw_last  = last_cell;
    assign score        = max_reg;

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_W'(MAX_LEVELS)) else $error("level index out of range");
    a_sweep_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sw_start |=> (addr_reg == '0 && max_reg == '0)) else $error("sweep not restarted");
    a_scale_reset: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_reset |=> (scale_reg == SCALE_ONE && level_reg == '0))
        else $error("walk not restarted");

endmodule

FILE: hdl/patch_overlap_heatmap_max.sv
// Patch overlap heat map with maximum overlap count.
// Input transactions: one per sliding-window patch, accepted at a rising edge where
// start is high and busy is low, carrying is_face and last_patch. Patches arrive in
// pyramid order: level by level, row by row, column by column.
// Result transactions: on the patch with last_patch set, score is presented for
// exactly one cycle with score_valid high; the receiver cannot stall it.
// After acceptance busy stays high until the patch is done, and no new patch is taken
// before busy drops; a positive patch keeps busy high longer than a negative one.
// Every pyramid level skipped, because the window does not fit or its rows are used
// up, lengthens the walk; a patch past the last level makes no map update. The four
// corner updates of a positive patch are read-modify-write pairs on the map memory.
// A last patch adds a prefix-sum sweep over all 66049 map cells, with one map read
// and one map write per cell; score_valid follows in the next cycle, with busy
// still high.
// After reset the map memory is cleared one cell per cycle with busy high;
// configuration writes over the APB port are taken at any time and should be
// made only while busy is low.
module patch_overlap_heatmap_max (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [4:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic                        is_face,
    input  logic                        last_patch,
    output logic                        score_valid,
    output logic [poh_pkg::SCORE_W-1:0] score
);
    import poh_pkg::*;

    logic [DIM_W-1:0]   width_reg, height_reg, patch_reg, stride_reg, minw_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic               wr_en;
    logic [2:0]         reg_idx;
    cfg_t               cfg;
    cmd_t               cmd;
    sts_t               sts;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(256);
            height_reg <= DIM_W'(256);
            patch_reg  <= DIM_W'(32);
            stride_reg <= DIM_W'(4);
            minw_reg   <= DIM_W'(32);
            ratio_reg  <= RATIO_W'(52429);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_PATCH_SIZE:   patch_reg  <= pwdata[DIM_W-1:0];
                REG_STRIDE_STEP:  stride_reg <= pwdata[DIM_W-1:0];
                REG_MIN_WIDTH:    minw_reg   <= pwdata[DIM_W-1:0];
                REG_SHRINK_RATIO: ratio_reg  <= pwdata[RATIO_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = 32'(width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(height_reg);
            REG_PATCH_SIZE:   prdata = 32'(patch_reg);
            REG_STRIDE_STEP:  prdata = 32'(stride_reg);
            REG_MIN_WIDTH:    prdata = 32'(minw_reg);
            REG_SHRINK_RATIO: prdata = 32'(ratio_reg);
            default:          prdata = '0;
        endcase
    end

    // A zero width, height, patch or stride acts as one; a width or height beyond the map saturates to the map size.
    always_comb
    begin
        cfg.w = (width_reg == '0) ? DIM_W'(1)
              : (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
        cfg.h = (height_reg == '0) ? DIM_W'(1)
              : (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;
        cfg.p     = (patch_reg == '0) ? DIM_W'(1) : patch_reg;
        cfg.st    = (stride_reg == '0) ? DIM_W'(1) : stride_reg;
        cfg.min_w = minw_reg;
        cfg.ratio = ratio_reg;
    end

    poh_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .is_face     (is_face),
        .last_patch  (last_patch),
        .sts         (sts),
        .cmd         (cmd),
        .busy        (busy),
        .score_valid (score_valid)
    );

    poh_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts),
        .score (score)
    );

endmodule
